FILE: rtl/dmtg_pkg.sv
// dmtg_pkg: types and constants of the mixed dram traffic generator
// shared by dmtg_csr, dmtg_mod and dram_mixed_traffic_generator_top
// no dependencies
`timescale 1ns / 1ps

package dmtg_pkg;

   localparam int CHAN_COUNT   = 2;
   localparam int ADDR_WIDTH   = 36;
   localparam int ROW_BITS     = 16;
   localparam int BANK_BITS    = 2;
   localparam int GROUP_BITS   = 2;
   localparam int SEND_RANDOM  = 1;

   localparam int IN_ADDR_W  = 36;
   localparam int OUT_ADDR_W = 40;
   localparam int COL_W      = 10;
   localparam int COLS_W     = 11;
   localparam int COLS_MAX   = 1024;
   localparam int SHIFT_W    = 6;
   localparam int PERIOD_W   = 16;
   localparam int TOTAL_W    = 32;
   localparam int CHAN_OUT_W = 3;
   localparam int CH_W       = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
   localparam int MOD_CNT_W  = $clog2(PERIOD_W + 1);

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [OUT_ADDR_W-1:0] oaddr_type;

   typedef enum logic [2:0] {
      REG_TOTAL_RANDOM   = 3'd0,
      REG_NOP_PERIOD     = 3'd1,
      REG_STREAM_COLUMNS = 3'd2,
      REG_CHANNEL_SHIFT  = 3'd3,
      REG_ROW_SHIFT      = 3'd4,
      REG_COLUMN_SHIFT   = 3'd5,
      REG_BANK_SHIFT     = 3'd6,
      REG_GROUP_SHIFT    = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  total_random;
      logic [PERIOD_W-1:0] nop_period;
      logic [COLS_W-1:0]   stream_columns;
      logic [SHIFT_W-1:0]  channel_shift;
      logic [SHIFT_W-1:0]  row_shift;
      logic [SHIFT_W-1:0]  column_shift;
      logic [SHIFT_W-1:0]  bank_shift;
      logic [SHIFT_W-1:0]  group_shift;
   } cfg_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] rem;
   } mod_sts_type;

endpackage

FILE: rtl/dmtg_csr.sv
// dmtg_csr: apb-style register file holding the generator configuration
// depends on dmtg_pkg
`timescale 1ns / 1ps

module dmtg_csr import dmtg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg,
   output logic              nop_wr
);

   cfg_type     cfg_ff, cfg_in;
   logic        nop_wr_ff, nop_wr_in;
   logic        wr_en;
   csr_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign idx    = csr_idx_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in    = cfg_ff;
      nop_wr_in = 1'b0;
      if (wr_en) begin
         case (idx)
            REG_TOTAL_RANDOM:   cfg_in.total_random   = pwdata[TOTAL_W-1:0];
            REG_NOP_PERIOD: begin
               cfg_in.nop_period = pwdata[PERIOD_W-1:0];
               nop_wr_in         = 1'b1;
            end
            REG_STREAM_COLUMNS: cfg_in.stream_columns = pwdata[COLS_W-1:0];
            REG_CHANNEL_SHIFT:  cfg_in.channel_shift  = pwdata[SHIFT_W-1:0];
            REG_ROW_SHIFT:      cfg_in.row_shift      = pwdata[SHIFT_W-1:0];
            REG_COLUMN_SHIFT:   cfg_in.column_shift   = pwdata[SHIFT_W-1:0];
            REG_BANK_SHIFT:     cfg_in.bank_shift     = pwdata[SHIFT_W-1:0];
            REG_GROUP_SHIFT:    cfg_in.group_shift    = pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_random   <= TOTAL_W'(1000);
         cfg_ff.nop_period     <= PERIOD_W'(1);
         cfg_ff.stream_columns <= COLS_W'(8);
         cfg_ff.channel_shift  <= SHIFT_W'(34);
         cfg_ff.row_shift      <= SHIFT_W'(18);
         cfg_ff.column_shift   <= SHIFT_W'(6);
         cfg_ff.bank_shift     <= SHIFT_W'(14);
         cfg_ff.group_shift    <= SHIFT_W'(16);
         nop_wr_ff             <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         nop_wr_ff <= nop_wr_in;
      end
   end

   always_comb begin
      case (idx)
         REG_TOTAL_RANDOM:   prdata = CSR_DW'(cfg_ff.total_random);
         REG_NOP_PERIOD:     prdata = CSR_DW'(cfg_ff.nop_period);
         REG_STREAM_COLUMNS: prdata = CSR_DW'(cfg_ff.stream_columns);
         REG_CHANNEL_SHIFT:  prdata = CSR_DW'(cfg_ff.channel_shift);
         REG_ROW_SHIFT:      prdata = CSR_DW'(cfg_ff.row_shift);
         REG_COLUMN_SHIFT:   prdata = CSR_DW'(cfg_ff.column_shift);
         REG_BANK_SHIFT:     prdata = CSR_DW'(cfg_ff.bank_shift);
         REG_GROUP_SHIFT:    prdata = CSR_DW'(cfg_ff.group_shift);
         default:            prdata = '0;
      endcase
   end

   assign cfg    = cfg_ff;
   // pulses the cycle after a period write, when the new value is visible
   assign nop_wr = nop_wr_ff;

endmodule

FILE: rtl/dmtg_mod.sv
// dmtg_mod: bit-serial remainder unit, one quotient bit per cycle
// renormalizes the idle counter after the idle period changes; depends on dmtg_pkg
`timescale 1ns / 1ps

module dmtg_mod import dmtg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PERIOD_W-1:0] dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output mod_sts_type         sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]  num_ff, num_in;
   logic [PERIOD_W-1:0]  div_ff, div_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W:0]    trial;

   assign trial = {rem_ff, num_ff[PERIOD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_W'(PERIOD_W);
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = PERIOD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[PERIOD_W-1:0];
         end
         cnt_in = cnt_ff - MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff | done_ff;
   assign sts.done = done_ff;
   assign sts.rem  = rem_ff;

endmodule

FILE: rtl/dram_mixed_traffic_generator_top.sv
// dram_mixed_traffic_generator_top: mixed random / stream dram request generator
// depends on dmtg_pkg, dmtg_csr, dmtg_mod
//
//   port group  dir   beat
//   req_*       in    one tick: random address, stream write bit, accept, done
//   rsp_*       out   one channel copy of the request attempted in a tick
//   csr_*       in    apb-style register writes and reads
//
// a tick is held in the input register and is resolved in one pass;
// a tick that attempts a request puts CHAN_COUNT copies on rsp_*, others none
// a tick with no request is taken while copies are still going out; one with a request waits for the last copy
// a write to nop_period holds off ticks while the idle count is reduced
// reset is synchronous and clears the walk, turn, retry and idle state
`timescale 1ns / 1ps

module dram_mixed_traffic_generator_top import dmtg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IN_ADDR_W-1:0]  req_random_addr,
   input  logic                  req_stream_wr,
   input  logic                  req_mem_accept,
   input  logic                  req_prev_random_done,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_ADDR_W-1:0] rsp_req_addr,
   output logic                  rsp_req_write,
   output logic                  rsp_req_kind,
   output logic [CHAN_OUT_W-1:0] rsp_req_channel,
   output logic                  rsp_req_last,
   output logic                  rsp_all_issued,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   logic        nop_wr;
   mod_sts_type mod_sts;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [IN_ADDR_W-1:0] in_addr_ff;
   logic                 in_wr_ff, in_acc_ff, in_done_ff;

   // generator state
   logic                  turn_ff, turn_in;
   logic [PERIOD_W-1:0]   idle_raw_ff, idle_raw_in;
   logic [PERIOD_W-1:0]   idle_red_ff, idle_red_in;
   logic [TOTAL_W-1:0]    issued_ff, issued_in;
   logic                  retry_r_ff, retry_r_in;
   logic                  retry_s_ff, retry_s_in;
   addr_type              held_r_ff, held_r_in;
   addr_type              held_s_ff, held_s_in;
   logic                  held_wr_ff, held_wr_in;
   logic                  outst_ff, outst_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [BANK_BITS-1:0]  bank_ff, bank_in;
   logic [GROUP_BITS-1:0] group_ff, group_in;

   // result record, sent once per channel
   logic            out_valid_ff, out_valid_in;
   addr_type        base_ff, base_in;
   logic            owr_ff, owr_in;
   logic            kind_ff, kind_in;
   logic            odone_ff, odone_in;
   logic [CH_W-1:0] chan_ff, chan_in;

   logic [PERIOD_W-1:0] period;
   logic [PERIOD_W-1:0] idle_step, idle_next;
   logic [COLS_W-1:0]   cols;
   logic                is_idle, stopped, blocked, sent, has_result;
   logic                consume, req_accept, rsp_accept, out_last, out_free, rec_load;
   addr_type            rnd_addr, r_addr, stream_addr, s_addr;
   logic                s_wr;
   logic [TOTAL_W-1:0]  issued_inc;

   dmtg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg),
      .nop_wr  (nop_wr)
   );

   dmtg_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (nop_wr),
      .dividend (idle_raw_ff),
      .divisor  (period),
      .sts      (mod_sts)
   );

   // ---- tick decode ----
   assign period    = (cfg.nop_period == '0) ? PERIOD_W'(1) : cfg.nop_period;
   // idle_red_ff is kept below period, so the step never overflows
   assign idle_step = idle_red_ff + PERIOD_W'(1);
   assign idle_next = (idle_step == period) ? '0 : idle_step;

   always_comb begin
      if (cfg.stream_columns == '0) begin
         cols = COLS_W'(1);
      end else if (cfg.stream_columns > COLS_W'(COLS_MAX)) begin
         cols = COLS_W'(COLS_MAX);
      end else begin
         cols = cfg.stream_columns;
      end
   end

   assign is_idle = !turn_ff && (idle_raw_ff != '0);
   assign stopped = issued_ff >= cfg.total_random;
   assign blocked = turn_ff && outst_ff && !in_done_ff;
   assign sent    = (SEND_RANDOM == 0) ? 1'b1 : in_acc_ff;

   assign issued_inc = (issued_ff == '1) ? issued_ff : issued_ff + TOTAL_W'(1);

   assign rnd_addr = addr_type'(in_addr_ff);
   assign r_addr   = retry_r_ff ? held_r_ff : rnd_addr;

   assign stream_addr = (addr_type'(row_ff)   << cfg.row_shift)
                      + (addr_type'(col_ff)   << cfg.column_shift)
                      + (addr_type'(bank_ff)  << cfg.bank_shift)
                      + (addr_type'(group_ff) << cfg.group_shift);
   assign s_addr = retry_s_ff ? held_s_ff : stream_addr;
   assign s_wr   = retry_s_ff ? held_wr_ff : in_wr_ff;

   assign has_result = !(is_idle || stopped) && !blocked
                       && (!turn_ff || (SEND_RANDOM != 0));

   // ---- handshakes ----
   assign out_last   = chan_ff == CH_W'(CHAN_COUNT - 1);
   assign rsp_accept = out_valid_ff && !rsp_stall;
   assign out_free   = !out_valid_ff || (rsp_accept && out_last);
   assign consume    = in_valid_ff && !mod_sts.busy && !nop_wr
                       && (!has_result || out_free);
   assign rec_load   = consume && has_result;
   assign req_stall  = in_valid_ff && !consume;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   // ---- state update ----
   always_comb begin
      turn_in     = turn_ff;
      idle_raw_in = idle_raw_ff;
      idle_red_in = idle_red_ff;
      issued_in   = issued_ff;
      retry_r_in  = retry_r_ff;
      retry_s_in  = retry_s_ff;
      held_r_in   = held_r_ff;
      held_s_in   = held_s_ff;
      held_wr_in  = held_wr_ff;
      outst_in    = outst_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      bank_in     = bank_ff;
      group_in    = group_ff;
      if (mod_sts.done) begin
         idle_red_in = mod_sts.rem;
      end
      if (consume) begin
         if (!turn_ff) begin
            idle_raw_in = idle_next;
            idle_red_in = idle_next;
         end
         if (is_idle || stopped) begin
            turn_in = !turn_ff;
         end else if (blocked) begin
            turn_in = 1'b0;
         end else if (turn_ff) begin
            held_r_in = r_addr;
            if (sent) begin
               issued_in  = issued_inc;
               outst_in   = 1'b1;
               turn_in    = 1'b0;
               retry_r_in = 1'b0;
            end else begin
               retry_r_in = 1'b1;
            end
         end else begin
            if (!retry_s_ff) begin
               held_s_in  = stream_addr;
               held_wr_in = in_wr_ff;
               // walk: group innermost, then bank, column, row
               group_in   = group_ff + GROUP_BITS'(1);
               if (group_ff == '1) begin
                  bank_in = bank_ff + BANK_BITS'(1);
                  if (bank_ff == '1) begin
                     if ({1'b0, col_ff} + COLS_W'(1) < cols) begin
                        col_in = col_ff + COL_W'(1);
                     end else begin
                        col_in = '0;
                        row_in = row_ff + ROW_BITS'(1);
                     end
                  end
               end
            end
            if (in_acc_ff) begin
               retry_s_in = 1'b0;
               turn_in    = 1'b1;
            end else begin
               retry_s_in = 1'b1;
            end
         end
      end
   end

   // ---- result record ----
   always_comb begin
      out_valid_in = out_valid_ff;
      chan_in      = chan_ff;
      base_in      = base_ff;
      owr_in       = owr_ff;
      kind_in      = kind_ff;
      odone_in     = odone_ff;
      if (rsp_accept) begin
         if (out_last) begin
            out_valid_in = 1'b0;
            chan_in      = '0;
         end else begin
            chan_in = chan_ff + CH_W'(1);
         end
      end
      if (rec_load) begin
         out_valid_in = 1'b1;
         chan_in      = '0;
         base_in      = turn_ff ? r_addr : s_addr;
         owr_in       = turn_ff ? 1'b0 : s_wr;
         kind_in      = !turn_ff;
         odone_in     = issued_in >= cfg.total_random;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         turn_ff      <= 1'b0;
         idle_raw_ff  <= '0;
         idle_red_ff  <= '0;
         issued_ff    <= '0;
         retry_r_ff   <= 1'b0;
         retry_s_ff   <= 1'b0;
         held_r_ff    <= '0;
         held_s_ff    <= '0;
         held_wr_ff   <= 1'b0;
         outst_ff     <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         bank_ff      <= '0;
         group_ff     <= '0;
         out_valid_ff <= 1'b0;
         chan_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         turn_ff      <= turn_in;
         idle_raw_ff  <= idle_raw_in;
         idle_red_ff  <= idle_red_in;
         issued_ff    <= issued_in;
         retry_r_ff   <= retry_r_in;
         retry_s_ff   <= retry_s_in;
         held_r_ff    <= held_r_in;
         held_s_ff    <= held_s_in;
         held_wr_ff   <= held_wr_in;
         outst_ff     <= outst_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bank_ff      <= bank_in;
         group_ff     <= group_in;
         out_valid_ff <= out_valid_in;
         chan_ff      <= chan_in;
      end
      if (req_accept) begin
         in_addr_ff <= req_random_addr;
         in_wr_ff   <= req_stream_wr;
         in_acc_ff  <= req_mem_accept;
         in_done_ff <= req_prev_random_done;
      end
      base_ff  <= base_in;
      owr_ff   <= owr_in;
      kind_ff  <= kind_in;
      odone_ff <= odone_in;
   end

   // ---- outputs ----
   assign rsp_valid       = out_valid_ff;
   assign rsp_req_addr    = oaddr_type'(base_ff)
                          + (oaddr_type'(chan_ff) << cfg.channel_shift);
   assign rsp_req_write   = owr_ff;
   assign rsp_req_kind    = kind_ff;
   assign rsp_req_channel = CHAN_OUT_W'(chan_ff);
   assign rsp_req_last    = out_last;
   assign rsp_all_issued  = odone_ff;

   // ---- assertions ----
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> chan_ff <= CH_W'(CHAN_COUNT - 1))
      else $error("channel copy index past last channel");

   a_copy_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(chan_ff))
      else $error("stalled channel copy advanced");

   a_random_retry: assert property (@(posedge clock) disable iff (reset)
      consume && turn_ff && !is_idle && !stopped && !blocked && !sent
      |=> retry_r_ff && turn_ff)
      else $error("rejected random read not held for retry");

   a_issued_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> issued_ff >= $past(issued_ff))
      else $error("random issue count decreased");

endmodule

FILE: sim/tb_dram_mixed_traffic_generator_top.sv
// testbench for dram_mixed_traffic_generator_top: drives ticks, predicts every channel copy
// and compares each rsp beat; depends on dmtg_pkg and the rtl of the generator
`timescale 1ns / 1ps

module tb_dram_mixed_traffic_generator_top;
   import dmtg_pkg::*;

   localparam logic KIND_RANDOM = 1'b0;
   localparam logic KIND_STREAM = 1'b1;
   localparam logic [63:0] ADDR_MASK64 = (64'd1 << ADDR_WIDTH) - 64'd1;
   localparam logic [63:0] OUT_MASK64  = (64'd1 << OUT_ADDR_W) - 64'd1;

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] addr;
      logic                  write;
      logic                  kind;
      logic [CHAN_OUT_W-1:0] channel;
      logic                  last;
      logic                  all_issued;
   } copy_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [IN_ADDR_W-1:0]  req_random_addr = '0;
   logic                  req_stream_wr = 1'b0;
   logic                  req_mem_accept = 1'b0;
   logic                  req_prev_random_done = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_ADDR_W-1:0] rsp_req_addr;
   logic                  rsp_req_write;
   logic                  rsp_req_kind;
   logic [CHAN_OUT_W-1:0] rsp_req_channel;
   logic                  rsp_req_last;
   logic                  rsp_all_issued;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   dram_mixed_traffic_generator_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_random_addr      (req_random_addr),
      .req_stream_wr        (req_stream_wr),
      .req_mem_accept       (req_mem_accept),
      .req_prev_random_done (req_prev_random_done),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_req_addr         (rsp_req_addr),
      .rsp_req_write        (rsp_req_write),
      .rsp_req_kind         (rsp_req_kind),
      .rsp_req_channel      (rsp_req_channel),
      .rsp_req_last         (rsp_req_last),
      .rsp_all_issued       (rsp_all_issued),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #5 clock = ~clock;

   // generator model state
   cfg_type                cfg_model = '{total_random: 32'd1000, nop_period: 16'd1,
                                         stream_columns: 11'd8, channel_shift: 6'd34,
                                         row_shift: 6'd18, column_shift: 6'd6,
                                         bank_shift: 6'd14, group_shift: 6'd16};
   logic                   turn_is_random = 1'b0;
   logic [PERIOD_W-1:0]    idle_ctr = '0;
   logic [TOTAL_W-1:0]     randoms_sent = '0;
   logic                   random_retry = 1'b0;
   logic                   stream_retry = 1'b0;
   logic [ADDR_WIDTH-1:0]  saved_random_addr = '0;
   logic [ADDR_WIDTH-1:0]  saved_stream_addr = '0;
   logic                   saved_stream_wr = 1'b0;
   logic                   random_in_flight = 1'b0;
   logic [ROW_BITS-1:0]    walk_row = '0;
   logic [COL_W-1:0]       walk_col = '0;
   logic [BANK_BITS-1:0]   walk_bank = '0;
   logic [GROUP_BITS-1:0]  walk_group = '0;

   copy_type expected_copies[$];
   int unsigned mismatch_count = 0;
   bit idle_enable = 1'b1;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_burst_left = 0;

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 100) $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic queue_channel_copies(logic [63:0] base, logic wr, logic kind);
      copy_type c;
      for (int ch = 0; ch < CHAN_COUNT; ch++) begin
         c.addr       = OUT_ADDR_W'((base + (64'(ch) << cfg_model.channel_shift)) & OUT_MASK64);
         c.write      = wr;
         c.kind       = kind;
         c.channel    = CHAN_OUT_W'(ch);
         c.last       = (ch == CHAN_COUNT - 1);
         c.all_issued = (randoms_sent >= cfg_model.total_random);
         expected_copies.insert(expected_copies.size(), c);
      end
   endtask

   // one tick of the generator, applied at the beat where the tick is accepted
   task automatic predict_tick(logic [IN_ADDR_W-1:0] rnd, logic swr, logic acc, logic done_prev);
      logic            idle;
      logic            sent;
      logic [31:0]     period;
      logic [31:0]     cols;
      logic [63:0]     addr;
      logic            wr;
      idle = !(idle_ctr == 0 || turn_is_random);
      if (!turn_is_random) begin
         period = (cfg_model.nop_period == 0) ? 32'd1 : 32'(cfg_model.nop_period);
         idle_ctr = PERIOD_W'((32'(idle_ctr) + 32'd1) % period);
      end
      if (idle || randoms_sent >= cfg_model.total_random) begin
         turn_is_random = !turn_is_random;
         return;
      end
      if (turn_is_random && random_in_flight && !done_prev) begin
         turn_is_random = 1'b0;
         return;
      end
      if (turn_is_random) begin
         addr = random_retry ? 64'(saved_random_addr) : (64'(rnd) & ADDR_MASK64);
         saved_random_addr = ADDR_WIDTH'(addr);
         sent = (SEND_RANDOM == 0) ? 1'b1 : acc;
         if (sent) begin
            if (randoms_sent != '1) randoms_sent++;
            random_in_flight = 1'b1;
            turn_is_random = 1'b0;
            random_retry = 1'b0;
         end else begin
            random_retry = 1'b1;
         end
         if (SEND_RANDOM != 0) queue_channel_copies(addr, 1'b0, KIND_RANDOM);
      end else begin
         if (stream_retry) begin
            addr = 64'(saved_stream_addr);
            wr = saved_stream_wr;
         end else begin
            addr = ((64'(walk_row) << cfg_model.row_shift)
                  + (64'(walk_col) << cfg_model.column_shift)
                  + (64'(walk_bank) << cfg_model.bank_shift)
                  + (64'(walk_group) << cfg_model.group_shift)) & ADDR_MASK64;
            wr = swr;
            saved_stream_addr = ADDR_WIDTH'(addr);
            saved_stream_wr = wr;
            // group innermost, then bank, then column, then row
            cols = 32'(cfg_model.stream_columns);
            if (cols == 0) cols = 1;
            if (cols > COLS_MAX) cols = COLS_MAX;
            walk_group = walk_group + 1'b1;
            if (walk_group == 0) begin
               walk_bank = walk_bank + 1'b1;
               if (walk_bank == 0) begin
                  if (32'(walk_col) + 32'd1 < cols) begin
                     walk_col = walk_col + 1'b1;
                  end else begin
                     walk_col = '0;
                     walk_row = walk_row + 1'b1;
                  end
               end
            end
         end
         if (acc) begin
            stream_retry = 1'b0;
            turn_is_random = 1'b1;
         end else begin
            stream_retry = 1'b1;
         end
         queue_channel_copies(addr, wr, KIND_STREAM);
      end
   endtask

   // result beats against the oldest expected copy
   always @(posedge clock) begin
      copy_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_copies.size() == 0) begin
            flag_mismatch($sformatf("copy with nothing expected, addr %h", rsp_req_addr));
         end else begin
            want = expected_copies.pop_front();
            if (rsp_req_addr !== want.addr)
               flag_mismatch($sformatf("req_addr %h, want %h", rsp_req_addr, want.addr));
            if (rsp_req_write !== want.write)
               flag_mismatch($sformatf("req_write %b, want %b", rsp_req_write, want.write));
            if (rsp_req_kind !== want.kind)
               flag_mismatch($sformatf("req_kind %b, want %b", rsp_req_kind, want.kind));
            if (rsp_req_channel !== want.channel)
               flag_mismatch($sformatf("req_channel %0d, want %0d", rsp_req_channel,
                                       want.channel));
            if (rsp_req_last !== want.last)
               flag_mismatch($sformatf("req_last %b, want %b", rsp_req_last, want.last));
            if (rsp_all_issued !== want.all_issued)
               flag_mismatch($sformatf("all_issued %b, want %b", rsp_all_issued,
                                       want.all_issued));
         end
      end
   end

   // receiver stall: long hold first, then random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else if (rsp_burst_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_burst_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst_left = $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // called at a rising edge; returns at the edge where the tick was taken
   task automatic send_tick(logic [IN_ADDR_W-1:0] addr, logic wr, logic acc, logic done);
      int gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_addr <= addr;
      req_stream_wr <= wr;
      req_mem_accept <= acc;
      req_prev_random_done <= done;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tick(addr, wr, acc, done);
   endtask

   task automatic send_random_ticks(int count, int acc_pct, int done_pct);
      logic [IN_ADDR_W-1:0] addr;
      for (int k = 0; k < count; k++) begin
         addr = IN_ADDR_W'({$urandom, $urandom});
         case ($urandom_range(0, 15))
            0: addr = '0;
            1: addr = '1;
            default: ;
         endcase
         send_tick(addr, 1'($urandom_range(0, 1)), 1'($urandom_range(1, 100) <= acc_pct),
                   1'($urandom_range(1, 100) <= done_pct));
      end
   endtask

   // wait out every expected copy, then the ticks that make none and the nop pass
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_copies.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] value);
      logic [31:0] want;
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_TOTAL_RANDOM:   cfg_model.total_random = value;
         REG_NOP_PERIOD:     cfg_model.nop_period = value[PERIOD_W-1:0];
         REG_STREAM_COLUMNS: cfg_model.stream_columns = value[COLS_W-1:0];
         REG_CHANNEL_SHIFT:  cfg_model.channel_shift = value[SHIFT_W-1:0];
         REG_ROW_SHIFT:      cfg_model.row_shift = value[SHIFT_W-1:0];
         REG_COLUMN_SHIFT:   cfg_model.column_shift = value[SHIFT_W-1:0];
         REG_BANK_SHIFT:     cfg_model.bank_shift = value[SHIFT_W-1:0];
         REG_GROUP_SHIFT:    cfg_model.group_shift = value[SHIFT_W-1:0];
         default: ;
      endcase
      case (idx)
         REG_TOTAL_RANDOM:   want = value;
         REG_NOP_PERIOD:     want = 32'(value[PERIOD_W-1:0]);
         REG_STREAM_COLUMNS: want = 32'(value[COLS_W-1:0]);
         default:            want = 32'(value[SHIFT_W-1:0]);
      endcase
      // read back in a second transfer
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== want) flag_mismatch($sformatf("register %s reads %h, want %h",
                                                idx.name(), got, want));
   endtask

   // nop_period goes last since its write starts the remainder pass
   task automatic set_traffic_config(logic [31:0] total, logic [15:0] nop, logic [10:0] cols,
                                     logic [5:0] ch_sh, logic [5:0] row_sh, logic [5:0] col_sh,
                                     logic [5:0] bank_sh, logic [5:0] grp_sh);
      csr_write(REG_TOTAL_RANDOM, total);
      csr_write(REG_STREAM_COLUMNS, 32'(cols));
      csr_write(REG_CHANNEL_SHIFT, 32'(ch_sh));
      csr_write(REG_ROW_SHIFT, 32'(row_sh));
      csr_write(REG_COLUMN_SHIFT, 32'(col_sh));
      csr_write(REG_BANK_SHIFT, 32'(bank_sh));
      csr_write(REG_GROUP_SHIFT, 32'(grp_sh));
      csr_write(REG_NOP_PERIOD, 32'(nop));
   endtask

   // reset values: retries on both kinds, done low with a read in flight, field extremes
   task automatic test_directed();
      send_tick('0, 1'b1, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1, 1'b0);
      send_tick('1, 1'b0, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1, 1'b0);
      send_tick('1, 1'b1, 1'b1, 1'b1);
      send_tick('1, 1'b0, 1'b1, 1'b0);
      send_tick(36'h5_A5A5_A5A5, 1'b0, 1'b1, 1'b0);
      send_tick(36'h5_A5A5_A5A5, 1'b0, 1'b1, 1'b1);
      send_tick('0, 1'b1, 1'b0, 1'b1);
      send_tick('1, 1'b0, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1, 1'b1);
      send_tick(36'h8_0000_0001, 1'b1, 1'b1, 1'b1);
      send_tick(36'hA_5A5A_5A5A, 1'b1, 1'b1, 1'b1);
      send_tick(36'h7_FFFF_FFFE, 1'b0, 1'b0, 1'b1);
      send_tick('1, 1'b0, 1'b1, 1'b1);
      send_tick('0, 1'b1, 1'b1, 1'b1);
      send_tick(36'h1_2345_6789, 1'b0, 1'b1, 1'b1);
      send_tick('1, 1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_random_traffic();
      drain_results();
      set_traffic_config('1, 16'd1, 11'd8, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      send_random_ticks(20, 80, 70);
   endtask

   // nop period above one, zero acting as one, and the widest period
   task automatic test_idle_throttle();
      drain_results();
      set_traffic_config('1, 16'd3, 11'd4, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      send_random_ticks(30, 80, 70);
      drain_results();
      set_traffic_config('1, 16'd0, 11'd8, 6'd33, 6'd20, 6'd8, 6'd12, 6'd10);
      send_random_ticks(15, 80, 70);
      drain_results();
      set_traffic_config('1, 16'hFFFF, 11'd8, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      send_random_ticks(15, 80, 70);
   endtask

   // one column per row so the walk steps rows quickly; shifts may overlap
   task automatic test_stream_walk();
      drain_results();
      set_traffic_config('1, 16'd1, 11'd1, 6'($urandom_range(0, 39)),
                         6'($urandom_range(0, 39)), 6'($urandom_range(0, 39)),
                         6'($urandom_range(0, 39)), 6'($urandom_range(0, 39)));
      send_random_ticks(30, 90, 80);
   endtask

   // column counts below and above the legal range, and shift extremes
   task automatic test_column_limits();
      drain_results();
      set_traffic_config('1, 16'd1, 11'd0, 6'd39, 6'd0, 6'd0, 6'd0, 6'd0);
      send_random_ticks(15, 85, 75);
      drain_results();
      set_traffic_config('1, 16'd2, 11'h7FF, 6'd0, 6'd39, 6'd30, 6'd35, 6'd33);
      send_random_ticks(15, 85, 75);
      drain_results();
      set_traffic_config('1, 16'd1, 11'd1024, 6'd39, 6'd25, 6'd39, 6'd1, 6'd3);
      send_random_ticks(15, 85, 75);
   endtask

   // long receiver hold fills the block, then a pause until all copies are back
   task automatic test_backpressure();
      drain_results();
      set_traffic_config('1, 16'd1, 11'd8, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      idle_enable = 1'b0;
      rsp_hold_left = 300;
      send_random_ticks(24, 90, 90);
      idle_enable = 1'b1;
      drain_results();
      send_random_ticks(16, 80, 70);
   endtask

   // reach the random total, then a zero total where nothing goes out
   task automatic test_issue_limit();
      drain_results();
      set_traffic_config(randoms_sent + 32'd3, 16'd1, 11'd8, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      send_random_ticks(25, 90, 90);
      drain_results();
      set_traffic_config(32'd0, 16'd2, 11'd8, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      send_random_ticks(8, 80, 80);
   endtask

   task automatic test_noise();
      drain_results();
      set_traffic_config('1, 16'($urandom_range(1, 4)), 11'($urandom_range(1, 16)),
                         6'($urandom_range(0, 39)), 6'($urandom_range(0, 39)),
                         6'($urandom_range(0, 39)), 6'($urandom_range(0, 39)),
                         6'($urandom_range(0, 39)));
      send_random_ticks(20, 40, 30);
   endtask

   task automatic test_final_steady();
      drain_results();
      set_traffic_config('1, 16'd1, 11'd2, 6'd34, 6'd18, 6'd6, 6'd14, 6'd16);
      idle_enable = 1'b0;
      send_random_ticks(30, 85, 85);
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_idle_throttle();
      test_stream_walk();
      test_column_limits();
      test_backpressure();
      test_issue_limit();
      test_noise();
      test_final_steady();
      if (expected_copies.size() != 0)
         flag_mismatch($sformatf("%0d copies never arrived", expected_copies.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
